[rtl/pwmd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwmd_pkg: shared types and constants
// Parser phases, event codes, register indexes and the front-to-back record.
// ----------------------------------------------------------------------------
package pwmd_pkg;

   typedef enum logic [3:0] {
      PH_SEEK, PH_RESV, PH_HASH, PH_PEER, PH_LEN, PH_ID, PH_HAVE, PH_BITF,
      PH_REQ, PH_PHDR, PH_PDATA, PH_SKIPQ, PH_SKIPU
   } phase_type;

   localparam logic [3:0] EV_HANDSHAKE = 4'd0;
   localparam logic [3:0] EV_KEEPALIVE = 4'd1;
   localparam logic [3:0] EV_CHOKE     = 4'd2;
   localparam logic [3:0] EV_HAVE      = 4'd6;
   localparam logic [3:0] EV_BITFIELD  = 4'd7;
   localparam logic [3:0] EV_REQUEST   = 4'd8;
   localparam logic [3:0] EV_PIECE     = 4'd9;

   localparam logic [7:0] ID_HAVE     = 8'd4;
   localparam logic [7:0] ID_BITFIELD = 8'd5;
   localparam logic [7:0] ID_REQUEST  = 8'd6;
   localparam logic [7:0] ID_PIECE    = 8'd7;

   localparam logic [1:0] REG_HASH_HIGH = 2'd0;
   localparam logic [1:0] REG_HASH_MID  = 2'd1;
   localparam logic [1:0] REG_HASH_LOW  = 2'd2;

   localparam int PREFIX_LEN = 20;

   typedef struct packed {
      logic [3:0]  event_res;
      logic        unhandled;
      logic        hash_match;
      logic [63:0] reserved_bits;
      logic [31:0] piece_index;
      logic [31:0] block_offset;
      logic [31:0] request_length;
      logic [7:0]  payload_byte;
      logic        last;
   } result_type;

   function automatic logic [7:0] prefix_byte(input logic [4:0] i);
      case (i)
         5'd0:  prefix_byte = 8'h13;
         5'd1:  prefix_byte = "B";
         5'd2:  prefix_byte = "i";
         5'd3:  prefix_byte = "t";
         5'd4:  prefix_byte = "T";
         5'd5:  prefix_byte = "o";
         5'd6:  prefix_byte = "r";
         5'd7:  prefix_byte = "r";
         5'd8:  prefix_byte = "e";
         5'd9:  prefix_byte = "n";
         5'd10: prefix_byte = "t";
         5'd11: prefix_byte = " ";
         5'd12: prefix_byte = "p";
         5'd13: prefix_byte = "r";
         5'd14: prefix_byte = "o";
         5'd15: prefix_byte = "t";
         5'd16: prefix_byte = "o";
         5'd17: prefix_byte = "c";
         5'd18: prefix_byte = "o";
         5'd19: prefix_byte = "l";
         default: prefix_byte = 8'h00;
      endcase
   endfunction

endpackage
`default_nettype wire

[rtl/pwmd_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwmd_parser: front end
// Takes one stream byte per cycle, tracks the framing and builds results.
// ----------------------------------------------------------------------------
module pwmd_parser
   import pwmd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         byte_valid,
   input  wire logic [7:0]   rx_byte,
   input  wire logic [159:0] expected_hash,
   output      logic         res_valid,
   output      result_type   res
);

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] mlen_ff, mlen_in;
   logic [31:0] index_ff, index_in;
   logic [31:0] begin_ff, begin_in;
   logic [31:0] length_ff, length_in;
   logic [63:0] resv_ff, resv_in;
   logic        hash_ok_ff, hash_ok_in;

   logic [31:0] cnt_next;
   logic        pay_end;
   logic [7:0]  exp_byte;
   logic [7:0]  b;

   assign b        = rx_byte;
   assign cnt_next = count_ff + 32'd1;
   assign pay_end  = (cnt_next == mlen_ff - 32'd1);
   // byte i of the hash sits at bits 159-8i
   assign exp_byte = (count_ff < 32'd20) ?
                     expected_hash[8'd159 - {count_ff[4:0], 3'b000} -: 8] : 8'h00;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      mlen_in    = mlen_ff;
      index_in   = index_ff;
      begin_in   = begin_ff;
      length_in  = length_ff;
      resv_in    = resv_ff;
      hash_ok_in = hash_ok_ff;
      res_valid  = 1'b0;
      res        = '0;
      case (phase_ff)
         PH_SEEK: begin
            if (count_ff < 32'd20 && b == prefix_byte(count_ff[4:0])) begin
               count_in = cnt_next;
               if (cnt_next == 32'd20) begin
                  phase_in   = PH_RESV;
                  count_in   = '0;
                  resv_in    = '0;
                  hash_ok_in = 1'b1;
               end
            end else begin
               count_in = (b == 8'h13) ? 32'd1 : 32'd0;
            end
         end
         PH_RESV: begin
            resv_in  = {resv_ff[55:0], b};
            count_in = cnt_next;
            if (cnt_next >= 32'd8) begin
               phase_in = PH_HASH;
               count_in = '0;
            end
         end
         PH_HASH: begin
            if (b != exp_byte) hash_ok_in = 1'b0;
            count_in = cnt_next;
            if (cnt_next >= 32'd20) begin
               phase_in = PH_PEER;
               count_in = '0;
            end
         end
         PH_PEER: begin
            count_in = cnt_next;
            if (cnt_next >= 32'd20) begin
               phase_in          = PH_LEN;
               count_in          = '0;
               mlen_in           = '0;
               res_valid         = 1'b1;
               res.event_res     = EV_HANDSHAKE;
               res.hash_match    = hash_ok_ff;
               res.reserved_bits = resv_ff;
            end
         end
         PH_LEN: begin
            mlen_in  = {mlen_ff[23:0], b};
            count_in = cnt_next;
            if (cnt_next >= 32'd4) begin
               count_in = '0;
               if ({mlen_ff[23:0], b} == 32'd0) begin
                  res_valid     = 1'b1;
                  res.event_res = EV_KEEPALIVE;
               end else begin
                  phase_in = PH_ID;
               end
            end
         end
         PH_ID: begin
            count_in  = '0;
            index_in  = '0;
            begin_in  = '0;
            length_in = '0;
            if (b <= 8'd3) begin
               phase_in      = (mlen_ff != 32'd1) ? PH_SKIPQ : PH_LEN;
               res_valid     = 1'b1;
               res.event_res = EV_CHOKE + b[3:0];
            end else if (b == ID_HAVE && mlen_ff >= 32'd5) begin
               phase_in = PH_HAVE;
            end else if (b == ID_BITFIELD) begin
               phase_in = (mlen_ff != 32'd1) ? PH_BITF : PH_LEN;
            end else if (b == ID_REQUEST && mlen_ff >= 32'd13) begin
               phase_in = PH_REQ;
            end else if (b == ID_PIECE && mlen_ff >= 32'd9) begin
               phase_in = PH_PHDR;
            end else if (mlen_ff != 32'd1) begin
               phase_in = PH_SKIPU;
            end else begin
               phase_in      = PH_LEN;
               res_valid     = 1'b1;
               res.event_res = EV_PIECE;
               res.unhandled = 1'b1;
            end
         end
         default: begin
            // payload phases
            count_in = pay_end ? 32'd0 : cnt_next;
            if (pay_end) mlen_in = '0;
            case (phase_ff)
               PH_HAVE: begin
                  if (count_ff < 32'd4) index_in = {index_ff[23:0], b};
                  if (count_ff == 32'd3) begin
                     phase_in        = pay_end ? PH_LEN : PH_SKIPQ;
                     res_valid       = 1'b1;
                     res.event_res   = EV_HAVE;
                     res.piece_index = {index_ff[23:0], b};
                  end
               end
               PH_BITF: begin
                  if (pay_end) phase_in = PH_LEN;
                  res_valid        = 1'b1;
                  res.event_res    = EV_BITFIELD;
                  res.payload_byte = b;
                  res.last         = pay_end;
               end
               PH_REQ: begin
                  if (count_ff < 32'd4) index_in = {index_ff[23:0], b};
                  else if (count_ff < 32'd8) begin_in = {begin_ff[23:0], b};
                  else if (count_ff < 32'd12) length_in = {length_ff[23:0], b};
                  if (count_ff == 32'd11) begin
                     phase_in           = pay_end ? PH_LEN : PH_SKIPQ;
                     res_valid          = 1'b1;
                     res.event_res      = EV_REQUEST;
                     res.piece_index    = index_ff;
                     res.block_offset   = begin_ff;
                     res.request_length = {length_ff[23:0], b};
                  end
               end
               PH_PHDR: begin
                  if (count_ff < 32'd4) index_in = {index_ff[23:0], b};
                  else begin_in = {begin_ff[23:0], b};
                  if (count_ff >= 32'd7) phase_in = pay_end ? PH_LEN : PH_PDATA;
               end
               PH_PDATA: begin
                  if (pay_end) phase_in = PH_LEN;
                  res_valid        = 1'b1;
                  res.event_res    = EV_PIECE;
                  res.piece_index  = index_ff;
                  res.block_offset = begin_ff + (count_ff - 32'd8);
                  res.payload_byte = b;
                  res.last         = pay_end;
               end
               PH_SKIPQ: begin
                  if (pay_end) phase_in = PH_LEN;
               end
               PH_SKIPU: begin
                  if (pay_end) begin
                     phase_in      = PH_LEN;
                     res_valid     = 1'b1;
                     res.event_res = EV_PIECE;
                     res.unhandled = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_SEEK;
                  count_in = '0;
               end
            endcase
         end
      endcase
      if (!byte_valid) res_valid = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEEK;
         count_ff   <= '0;
         mlen_ff    <= '0;
         index_ff   <= '0;
         begin_ff   <= '0;
         length_ff  <= '0;
         resv_ff    <= '0;
         hash_ok_ff <= 1'b1;
      end else if (byte_valid) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         mlen_ff    <= mlen_in;
         index_ff   <= index_in;
         begin_ff   <= begin_in;
         length_ff  <= length_in;
         resv_ff    <= resv_in;
         hash_ok_ff <= hash_ok_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      byte_valid && phase_ff == PH_SEEK |=> !$past(res_valid))
      else $error("event raised while seeking prefix");
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.last |-> res.event_res == EV_BITFIELD || res.event_res == EV_PIECE)
      else $error("last flag on a non-payload event");
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.unhandled |-> res.event_res == EV_PIECE)
      else $error("unhandled flag with wrong event code");

endmodule
`default_nettype wire

[rtl/pwmd_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwmd_fifo: result queue
// Holds parsed results between the parser and the consumer.
// ----------------------------------------------------------------------------
module pwmd_fifo
   import pwmd_pkg::*;
#(
   parameter int DEPTH_LOG2 = 2
)
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_en,
   input  result_type wr_data,
   output      logic full,
   input  wire logic rd_en,
   output      logic empty,
   output      result_type rd_data
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   result_type mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wptr_ff, rptr_ff;
   logic [DEPTH_LOG2:0]   cnt_ff;

   assign full    = (cnt_ff == (DEPTH_LOG2+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en && !full) mem_ff[wptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (wr_en && !full) wptr_ff <= wptr_ff + 1'b1;
         if (rd_en && !empty) rptr_ff <= rptr_ff + 1'b1;
         cnt_ff <= cnt_ff + (DEPTH_LOG2+1)'(wr_en && !full)
                          - (DEPTH_LOG2+1)'(rd_en && !empty);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("queue full and empty at once");
   assert property (@(posedge clock) disable iff (reset)
      wr_en && !full && !(rd_en && !empty) |=> !empty)
      else $error("write lost");

endmodule
`default_nettype wire

[rtl/peer_wire_message_deframer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// peer_wire_message_deframer: peer-wire handshake and message deframer
// Finds the handshake, checks the info hash, then splits length-prefixed
// messages into events.
// ----------------------------------------------------------------------------
//  channel | ports                          | beat
//  req     | req_push, req_full, req_rx_byte | one stream byte
//  rsp     | rsp_empty, rsp_pop, rsp_*       | one event
//  csr     | csr_write, csr_index, csr_data  | one register write
//
// One byte per cycle while req_full is low; the parser updates state in the cycle of the beat.
// A result is registered in res_ff and written into the queue from there.
// req_full rises when the queue is full, or when a result is in flight, the
// queue plus that result leave at most one free slot and no pop is taken.
// Reset clears parser state, queue and hash registers.
module peer_wire_message_deframer
   import pwmd_pkg::*;
#(
   parameter int QUEUE_DEPTH_LOG2 = 2
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output      logic        req_full,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_empty,
   input  wire logic        rsp_pop,
   output      logic [3:0]  rsp_event_res,
   output      logic        rsp_unhandled,
   output      logic        rsp_hash_match,
   output      logic [63:0] rsp_reserved_bits,
   output      logic [31:0] rsp_piece_index,
   output      logic [31:0] rsp_block_offset,
   output      logic [31:0] rsp_request_length,
   output      logic [7:0]  rsp_payload_byte,
   output      logic        rsp_last,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   logic [63:0] hash_high_ff, hash_mid_ff;
   logic [31:0] hash_low_ff;
   logic        accept;
   logic        res_valid;
   result_type  res, res_ff, q_out;
   logic        res_valid_ff;
   logic        q_full;
   logic [QUEUE_DEPTH_LOG2:0] in_flight;
   logic        cnt_near_full;
   logic [QUEUE_DEPTH_LOG2:0] occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_high_ff <= '0;
         hash_mid_ff  <= '0;
         hash_low_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_HASH_HIGH: hash_high_ff <= csr_data;
            REG_HASH_MID:  hash_mid_ff  <= csr_data;
            REG_HASH_LOW:  hash_low_ff  <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // one slot of slack covers the registered result in flight
   assign in_flight = {{QUEUE_DEPTH_LOG2{1'b0}}, res_valid_ff};
   assign cnt_near_full = (occ_ff + in_flight)
                          >= (QUEUE_DEPTH_LOG2+1)'((1 << QUEUE_DEPTH_LOG2) - 1);
   assign req_full  = q_full || (res_valid_ff && !(rsp_pop && !rsp_empty)
                      && cnt_near_full);
   assign accept = req_push && !req_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_ff + (QUEUE_DEPTH_LOG2+1)'(res_valid_ff && !q_full)
                          - (QUEUE_DEPTH_LOG2+1)'(rsp_pop && !rsp_empty);
      end
   end

   pwmd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .byte_valid    (accept),
      .rx_byte       (req_rx_byte),
      .expected_hash ({hash_high_ff, hash_mid_ff, hash_low_ff}),
      .res_valid     (res_valid),
      .res           (res)
   );

   always_ff @(posedge clock) begin
      if (reset) res_valid_ff <= 1'b0;
      else       res_valid_ff <= res_valid;
      res_ff <= res;
   end

   pwmd_fifo #(.DEPTH_LOG2(QUEUE_DEPTH_LOG2)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_valid_ff),
      .wr_data (res_ff),
      .full    (q_full),
      .rd_en   (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (q_out)
   );

   assign rsp_event_res      = q_out.event_res;
   assign rsp_unhandled      = q_out.unhandled;
   assign rsp_hash_match     = q_out.hash_match;
   assign rsp_reserved_bits  = q_out.reserved_bits;
   assign rsp_piece_index    = q_out.piece_index;
   assign rsp_block_offset   = q_out.block_offset;
   assign rsp_request_length = q_out.request_length;
   assign rsp_payload_byte   = q_out.payload_byte;
   assign rsp_last           = q_out.last;

   assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> !q_full)
      else $error("result dropped at full queue");
   assert property (@(posedge clock) disable iff (reset)
      !accept |=> !res_valid_ff)
      else $error("result without an accepted byte");

endmodule
`default_nettype wire
